FILE: hw/rtl/convex_polytope_vertex_containment_assert.svh
// Assertion macros used by the checker file of the polytope containment block.
`ifndef CONVEX_POLYTOPE_VERTEX_CONTAINMENT_ASSERT_SVH
`define CONVEX_POLYTOPE_VERTEX_CONTAINMENT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPVC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cpvc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cpvc assertion failed");

`endif

FILE: hw/rtl/cpvc_pkg.sv
// Types, codes and constants of the polytope vertex containment block.
`timescale 1ns / 1ps
`default_nettype none
package cpvc_pkg;

	localparam int MAX_PLANES_DEF    = 32;
	localparam int MAX_POLYTOPES_DEF = 1024;
	localparam int MAX_VERTICES      = 32;

	localparam int IDX_W   = 10;
	localparam int VN_W    = 5;
	localparam int VNC_W   = 7;
	localparam int PROD_W  = 40;
	localparam int DIST_W  = 48;
	localparam int OFF_SH  = 14;
	localparam int PLANE_W = 80;
	localparam int APB_AW  = 3;

	localparam logic [1:0] REQ_OPEN   = 2'd0;
	localparam logic [1:0] REQ_PLANE  = 2'd1;
	localparam logic [1:0] REQ_VERTEX = 2'd2;

	localparam logic [2:0] ST_OPENED   = 3'd0;
	localparam logic [2:0] ST_MARKED   = 3'd1;
	localparam logic [2:0] ST_MISS     = 3'd2;
	localparam logic [2:0] ST_STORED   = 3'd3;
	localparam logic [2:0] ST_IGNORED  = 3'd4;
	localparam logic [2:0] ST_HIT      = 3'd5;
	localparam logic [2:0] ST_OVERFLOW = 3'd6;

	localparam logic REG_CONTENT_MASK = 1'b0;
	localparam logic REG_SUBMODEL     = 1'b1;

	localparam logic [31:0] FEATURE_FLAG      = 32'h8000_0000;
	localparam logic [31:0] FEATURE_SUB_MASK  = 32'h1FFF_0000;
	localparam int          FEATURE_SUB_SHIFT = 16;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [9:0]         polytope_index;
		logic [31:0]        polytope_contents;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [31:0] plane_offset;
		logic signed [23:0] vertex_x;
		logic signed [23:0] vertex_y;
		logic signed [23:0] vertex_z;
		logic [4:0]         vertex_number;
	} cpvc_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  nearest_plane;
		logic [4:0]  hit_vertex;
		logic [31:0] model_feature;
	} cpvc_out_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_MARK,
		S_WALK,
		S_DRAIN,
		S_FIN
	} cpvc_state_t;

	typedef struct packed {
		logic load_item;
		logic mark_rd;
		logic open_exec;
		logic simple_exec;
		logic walk_start;
		logic walk_step;
		logic walk_end;
		logic clr_step;
		logic out_load;
	} cpvc_cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic       walk_needed;
		logic       walk_last;
		logic       pipe_busy;
		logic       clr_last;
		logic       out_free;
	} cpvc_sts_t;

	function automatic logic [31:0] make_feature(logic [12:0] sub, logic [15:0] poly);
		return FEATURE_FLAG | ((32'(sub) << FEATURE_SUB_SHIFT) & FEATURE_SUB_MASK)
			| 32'(poly);
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/cpvc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cpvc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/cpvc_ctrl.sv
// Controller state machine: sequences clearing, open, plane and vertex items.
`timescale 1ns / 1ps
`default_nettype none
module cpvc_ctrl
	import cpvc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	output logic           item_stall,
	input  wire cpvc_sts_t sts,
	output cpvc_cmd_t      cmd
);

	cpvc_state_t state_q;
	cpvc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.req)
					REQ_OPEN: begin
						cmd.mark_rd = 1'b1;
						state_d     = S_MARK;
					end
					REQ_VERTEX: begin
						if (sts.walk_needed) begin
							cmd.walk_start = 1'b1;
							state_d        = S_WALK;
						end else begin
							cmd.simple_exec = 1'b1;
							state_d         = S_FIN;
						end
					end
					default: begin
						cmd.simple_exec = 1'b1;
						state_d         = S_FIN;
					end
				endcase
			end
			S_MARK: begin
				cmd.open_exec = 1'b1;
				state_d       = S_FIN;
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// wait for the last plane to leave the distance pipeline
				if (!sts.pipe_busy) begin
					cmd.walk_end = 1'b1;
					state_d      = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: hw/rtl/cpvc_datapath.sv
// Datapath: item registers, mark and plane memories, distance pipeline, result register.
`timescale 1ns / 1ps
`default_nettype none
module cpvc_datapath
	import cpvc_pkg::*;
#(
	parameter int MAX_PLANES    = MAX_PLANES_DEF,
	parameter int MAX_POLYTOPES = MAX_POLYTOPES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cpvc_in_t    item,
	input  wire cpvc_cmd_t   cmd,
	output cpvc_sts_t        sts,
	output cpvc_out_t        res,
	output logic             res_valid,
	input  wire logic        res_stall,
	input  wire logic [31:0] content_mask,
	input  wire logic [12:0] submodel_number
);

	localparam int PLW       = $clog2(MAX_PLANES);
	localparam int PCW       = $clog2(MAX_PLANES + 1);
	localparam int PIW       = $clog2(MAX_POLYTOPES);
	localparam int MOD_STEPS = $clog2(((1 << IDX_W) - 1) / MAX_POLYTOPES + 1);
	localparam int MOD_W     = ((PIW > IDX_W) ? PIW : IDX_W) + MOD_STEPS + 1;

	// item and open-polytope state
	cpvc_in_t         item_q;
	logic [PIW-1:0]   idx_q;
	logic [PIW-1:0]   cur_q;
	logic [PCW-1:0]   count_q;
	logic             active_q;
	logic             hit_q;
	logic [PIW-1:0]   clr_ptr_q;

	// plane walk
	logic [PCW-1:0]   ptr_q;
	logic             rdv_q;
	logic             v_s1;
	logic             v_s2;
	logic [PLW-1:0]   idx_rd_q;
	logic [PLW-1:0]   idx_s1;
	logic [PLW-1:0]   idx_s2;
	logic signed [PROD_W-1:0] prod_x_s1;
	logic signed [PROD_W-1:0] prod_y_s1;
	logic signed [PROD_W-1:0] prod_z_s1;
	logic signed [31:0]       off_s1;
	logic signed [DIST_W-1:0] dist_s2;
	logic signed [DIST_W-1:0] best_d_q;
	logic [PLW-1:0]   best_q;
	logic             first_q;
	logic             outside_q;

	cpvc_out_t        res_q;
	cpvc_out_t        out_q;
	logic             out_valid_q;

	logic [MOD_W-1:0] rem;
	logic [PIW-1:0]   idx_next;
	logic [0:0]       mark_rdata;
	logic [PLANE_W-1:0] plane_rdata;
	logic             plane_store;
	logic             vn_ok;
	logic [31:0]      feature;
	cpvc_out_t        open_res;
	cpvc_out_t        simple_res;
	cpvc_out_t        walk_res;

	logic signed [15:0] rd_nx;
	logic signed [15:0] rd_ny;
	logic signed [15:0] rd_nz;
	logic signed [31:0] rd_off;
	logic signed [23:0] vx;
	logic signed [23:0] vy;
	logic signed [23:0] vz;

	// wrap the index into the mark store by restoring subtraction
	always_comb begin
		rem = MOD_W'(item.polytope_index);
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			if (rem >= (MOD_W'(MAX_POLYTOPES) << k)) begin
				rem = rem - (MOD_W'(MAX_POLYTOPES) << k);
			end
		end
	end
	assign idx_next = rem[PIW-1:0];

	cpvc_ram #(
		.WIDTH(1),
		.DEPTH(MAX_POLYTOPES)
	) u_mark_ram (
		.clk  (clk),
		.we   (cmd.clr_step | cmd.open_exec),
		.waddr(cmd.clr_step ? clr_ptr_q : idx_q),
		.wdata(cmd.open_exec),
		.re   (cmd.mark_rd),
		.raddr(idx_q),
		.rdata(mark_rdata)
	);

	cpvc_ram #(
		.WIDTH(PLANE_W),
		.DEPTH(MAX_PLANES)
	) u_plane_ram (
		.clk  (clk),
		.we   (plane_store),
		.waddr(count_q[PLW-1:0]),
		.wdata({item_q.normal_x, item_q.normal_y, item_q.normal_z, item_q.plane_offset}),
		.re   (cmd.walk_step),
		.raddr(ptr_q[PLW-1:0]),
		.rdata(plane_rdata)
	);

	assign rd_nx  = plane_rdata[79:64];
	assign rd_ny  = plane_rdata[63:48];
	assign rd_nz  = plane_rdata[47:32];
	assign rd_off = plane_rdata[31:0];
	assign vx     = item_q.vertex_x;
	assign vy     = item_q.vertex_y;
	assign vz     = item_q.vertex_z;

	assign vn_ok   = {2'b00, item_q.vertex_number} < VNC_W'(MAX_VERTICES);
	assign feature = make_feature(submodel_number, 16'(cur_q));

	assign plane_store = cmd.simple_exec && (item_q.req_type == REQ_PLANE) && active_q
		&& (count_q != PCW'(MAX_PLANES));

	always_comb begin
		open_res = '0;
		if (mark_rdata[0]) begin
			open_res.status = ST_MARKED;
		end else if ((item_q.polytope_contents & content_mask) == 32'd0) begin
			open_res.status = ST_MISS;
		end else begin
			open_res.status = ST_OPENED;
		end
	end

	always_comb begin
		simple_res        = '0;
		simple_res.status = ST_IGNORED;
		case (item_q.req_type)
			REQ_PLANE: begin
				if (active_q) begin
					simple_res.status = plane_store ? ST_STORED : ST_OVERFLOW;
				end
			end
			REQ_VERTEX: begin
				// no planes stored: the vertex counts as inside
				if (active_q && !hit_q && vn_ok) begin
					simple_res.status        = ST_HIT;
					simple_res.hit_vertex    = item_q.vertex_number;
					simple_res.model_feature = feature;
				end
			end
			default: begin
				simple_res.status = ST_IGNORED;
			end
		endcase
	end

	always_comb begin
		walk_res        = '0;
		walk_res.status = ST_IGNORED;
		if (!outside_q) begin
			walk_res.status        = ST_HIT;
			walk_res.nearest_plane = 5'(best_q);
			walk_res.hit_vertex    = item_q.vertex_number;
			walk_res.model_feature = feature;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			count_q     <= '0;
			active_q    <= 1'b0;
			hit_q       <= 1'b0;
			clr_ptr_q   <= '0;
			ptr_q       <= '0;
			rdv_q       <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			first_q     <= 1'b0;
			outside_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rdv_q <= cmd.walk_step;
			v_s1  <= rdv_q;
			v_s2  <= v_s1;
			if (cmd.clr_step) begin
				clr_ptr_q <= clr_ptr_q + PIW'(1);
			end
			if (cmd.open_exec) begin
				cur_q    <= idx_q;
				count_q  <= '0;
				hit_q    <= 1'b0;
				active_q <= !mark_rdata[0] && ((item_q.polytope_contents & content_mask) != 32'd0);
			end
			if (plane_store) begin
				count_q <= count_q + PCW'(1);
			end
			if (cmd.simple_exec && simple_res.status == ST_HIT) begin
				hit_q <= 1'b1;
			end
			if (cmd.walk_end && !outside_q) begin
				hit_q <= 1'b1;
			end
			if (cmd.walk_start) begin
				ptr_q     <= '0;
				first_q   <= 1'b1;
				outside_q <= 1'b0;
			end
			if (cmd.walk_step) begin
				ptr_q <= ptr_q + PCW'(1);
			end
			if (v_s2) begin
				first_q <= 1'b0;
				// distance at or above zero puts the vertex outside
				if (!dist_s2[DIST_W-1]) begin
					outside_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item;
			idx_q  <= idx_next;
		end
		if (cmd.walk_step) begin
			idx_rd_q <= ptr_q[PLW-1:0];
		end
		prod_x_s1 <= rd_nx * vx;
		prod_y_s1 <= rd_ny * vy;
		prod_z_s1 <= rd_nz * vz;
		off_s1    <= rd_off;
		idx_s1    <= idx_rd_q;
		dist_s2   <= {{(DIST_W-PROD_W){prod_x_s1[PROD_W-1]}}, prod_x_s1}
			+ {{(DIST_W-PROD_W){prod_y_s1[PROD_W-1]}}, prod_y_s1}
			+ {{(DIST_W-PROD_W){prod_z_s1[PROD_W-1]}}, prod_z_s1}
			+ {{(DIST_W-32-OFF_SH){off_s1[31]}}, off_s1, OFF_SH'(0)};
		idx_s2    <= idx_s1;
		if (v_s2 && dist_s2[DIST_W-1] && (first_q || dist_s2 > best_d_q)) begin
			best_d_q <= dist_s2;
			best_q   <= idx_s2;
		end
		if (cmd.open_exec) begin
			res_q <= open_res;
		end else if (cmd.simple_exec) begin
			res_q <= simple_res;
		end else if (cmd.walk_end) begin
			res_q <= walk_res;
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign sts.req         = item_q.req_type;
	assign sts.walk_needed = active_q && !hit_q && vn_ok && (count_q != '0);
	assign sts.walk_last   = PCW'(ptr_q + PCW'(1)) == count_q;
	assign sts.pipe_busy   = rdv_q | v_s1 | v_s2;
	assign sts.clr_last    = clr_ptr_q == PIW'(MAX_POLYTOPES - 1);
	assign sts.out_free    = !out_valid_q || !res_stall;

	assign res       = out_q;
	assign res_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: hw/rtl/convex_polytope_vertex_containment.sv
// Top level of the convex polytope vertex containment block.
//
//   channel   direction   handshake               payload
//   item      in          item_valid/item_stall   cpvc_in_t
//   res       out         res_valid/res_stall     cpvc_out_t
//   apb       in/out      psel/penable/pready     paddr, pwdata, prdata
//
// A vertex item that walks the stored planes reads one plane per cycle from the plane
// memory. After reset the mark memory is cleared with item_stall high. One item is worked
// at a time; a finished result waits in the output register while the next item is
// accepted.
`timescale 1ns / 1ps
`default_nettype none
module convex_polytope_vertex_containment
	import cpvc_pkg::*;
#(
	parameter int MAX_PLANES    = MAX_PLANES_DEF,
	parameter int MAX_POLYTOPES = MAX_POLYTOPES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire cpvc_in_t          item,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output cpvc_out_t              res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	logic [31:0] content_mask_q;
	logic [12:0] submodel_q;
	cpvc_cmd_t   cmd;
	cpvc_sts_t   sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			content_mask_q <= '0;
			submodel_q     <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_CONTENT_MASK: content_mask_q <= pwdata;
				REG_SUBMODEL:     submodel_q     <= pwdata[12:0];
				default:          content_mask_q <= content_mask_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_CONTENT_MASK: prdata = content_mask_q;
			REG_SUBMODEL:     prdata = 32'(submodel_q);
			default:          prdata = '0;
		endcase
	end

	cpvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	cpvc_datapath #(
		.MAX_PLANES   (MAX_PLANES),
		.MAX_POLYTOPES(MAX_POLYTOPES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item),
		.cmd            (cmd),
		.sts            (sts),
		.res            (res),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.content_mask   (content_mask_q),
		.submodel_number(submodel_q)
	);

endmodule
`default_nettype wire

FILE: hw/rtl/cpvc_checker.sv
// Port-level checker for the polytope containment block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "convex_polytope_vertex_containment_assert.svh"
module cpvc_checker
	import cpvc_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      item_valid,
	input wire logic      item_stall,
	input wire logic      res_valid,
	input wire logic      res_stall,
	input wire cpvc_out_t res
);

	// results other than a hit carry no plane, vertex or feature
	`CPVC_ASSERT_SAME(a_quiet_fields, clk, arst_n, res_valid && res.status != ST_HIT, res.nearest_plane == 5'd0 && res.hit_vertex == 5'd0 && res.model_feature == 32'd0)
	`CPVC_ASSERT_SAME(a_hit_feature, clk, arst_n, res_valid && res.status == ST_HIT, res.model_feature[31] && res.model_feature[30:29] == 2'b00)
	// one item at a time: an accept is followed by a busy cycle
	`CPVC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item_valid && !item_stall, item_stall)
	`CPVC_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res))

endmodule

bind convex_polytope_vertex_containment cpvc_checker u_cpvc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.item_valid(item_valid),
	.item_stall(item_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the convex polytope vertex containment block.
`timescale 1ns / 1ps
module tb;
	import cpvc_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = MAX_PLANES_DEF + 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	cpvc_in_t item = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	cpvc_out_t res;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// predictor state
	bit [MAX_POLYTOPES_DEF-1:0] visited = '0;
	logic signed [15:0] held_nx[MAX_PLANES_DEF];
	logic signed [15:0] held_ny[MAX_PLANES_DEF];
	logic signed [15:0] held_nz[MAX_PLANES_DEF];
	logic signed [31:0] held_off[MAX_PLANES_DEF];
	int planes_held = 0;
	bit poly_open = 1'b0;
	bit hit_taken = 1'b0;
	logic [9:0] open_poly = '0;
	logic [31:0] mask_reg = '0;
	logic [12:0] submodel_reg = '0;

	cpvc_out_t pending_verdicts[$];
	int fail_count = 0;
	int items_worked = 0;
	int items_sent = 0;
	int marks_used = 0;
	int status_seen[8] = '{default: 0};
	int cycles = 0;
	bit quiet_run = 1'b0;
	logic [9:0] last_opened = '0;

	convex_polytope_vertex_containment u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		res_stall <= arst_n && !quiet_run && ($urandom_range(0, 99) < 18);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_verdicts.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		cpvc_out_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_verdicts.size() == 0) begin
				$error("result with nothing outstanding: status %0d", res.status);
				fail_count++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("status", 32'(want.status), 32'(res.status));
				check_field("nearest_plane", 32'(want.nearest_plane), 32'(res.nearest_plane));
				check_field("hit_vertex", 32'(want.hit_vertex), 32'(res.hit_vertex));
				check_field("model_feature", want.model_feature, res.model_feature);
			end
		end
	end

	// Work out the result of one accepted item and advance the predictor state.
	function automatic cpvc_out_t resolve_containment(cpvc_in_t it);
		cpvc_out_t r;
		bit was;
		bit is_inside;
		longint plane_dist;
		longint best_dist;
		int best;
		r = '0;
		r.status = ST_IGNORED;
		case (it.req_type)
			REQ_OPEN: begin
				was = visited[it.polytope_index];
				if (!was)
					marks_used++;
				visited[it.polytope_index] = 1'b1;
				open_poly = it.polytope_index;
				planes_held = 0;
				hit_taken = 1'b0;
				items_worked++;
				if (was) begin
					poly_open = 1'b0;
					r.status = ST_MARKED;
				end else if ((it.polytope_contents & mask_reg) == 32'd0) begin
					poly_open = 1'b0;
					r.status = ST_MISS;
				end else begin
					poly_open = 1'b1;
					r.status = ST_OPENED;
				end
			end
			REQ_PLANE: begin
				if (poly_open) begin
					items_worked++;
					if (planes_held >= MAX_PLANES_DEF) begin
						r.status = ST_OVERFLOW;
					end else begin
						held_nx[planes_held] = it.normal_x;
						held_ny[planes_held] = it.normal_y;
						held_nz[planes_held] = it.normal_z;
						held_off[planes_held] = it.plane_offset;
						planes_held++;
						r.status = ST_STORED;
					end
				end
			end
			REQ_VERTEX: begin
				if (poly_open && !hit_taken && it.vertex_number < MAX_VERTICES) begin
					items_worked++;
					is_inside = 1'b1;
					best = 0;
					best_dist = 0;
					for (int k = 0; k < planes_held; k++) begin
						plane_dist = longint'(held_nx[k]) * longint'($signed(it.vertex_x))
							+ longint'(held_ny[k]) * longint'($signed(it.vertex_y))
							+ longint'(held_nz[k]) * longint'($signed(it.vertex_z))
							+ longint'(held_off[k]) * 64'sd16384;
						// at or above zero on any plane: outside
						if (plane_dist >= 0) begin
							is_inside = 1'b0;
							break;
						end
						if (k == 0 || plane_dist > best_dist) begin
							best_dist = plane_dist;
							best = k;
						end
					end
					if (is_inside) begin
						hit_taken = 1'b1;
						r.status = ST_HIT;
						r.nearest_plane = 5'(best);
						r.hit_vertex = it.vertex_number;
						r.model_feature = FEATURE_FLAG
							| ((32'(submodel_reg) << FEATURE_SUB_SHIFT) & FEATURE_SUB_MASK)
							| 32'(open_poly);
					end
				end
			end
			default: ;
		endcase
		status_seen[r.status]++;
		return r;
	endfunction

	function automatic logic signed [15:0] rand_normal();
		return 16'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic logic signed [23:0] rand_coord(int span);
		return 24'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic cpvc_in_t random_item();
		cpvc_in_t it;
		it.req_type = 2'($urandom_range(0, 3));
		it.polytope_index = 10'($urandom());
		it.polytope_contents = $urandom();
		it.normal_x = rand_normal();
		it.normal_y = rand_normal();
		it.normal_z = rand_normal();
		it.plane_offset = $urandom();
		it.vertex_x = 24'($urandom());
		it.vertex_y = 24'($urandom());
		it.vertex_z = 24'($urandom());
		it.vertex_number = 5'($urandom());
		return it;
	endfunction

	// Pick a polytope that has not been marked yet while enough unmarked ones remain; the ends are kept for directed use.
	function automatic logic [9:0] fresh_index();
		logic [9:0] idx;
		idx = 10'($urandom_range(1, MAX_POLYTOPES_DEF - 2));
		while (marks_used < MAX_POLYTOPES_DEF - 24 && visited[idx])
			idx = 10'($urandom_range(1, MAX_POLYTOPES_DEF - 2));
		return idx;
	endfunction

	// Entered and left at a falling edge.
	task automatic push_item(input cpvc_in_t it);
		while (!quiet_run && $urandom_range(0, 99) < 18) begin
			item_valid <= 1'b0;
			item <= random_item();
			@(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		if (it.req_type == REQ_OPEN)
			last_opened = it.polytope_index;
		items_sent++;
		pending_verdicts.push_back(resolve_containment(it));
		@(negedge clk);
	endtask

	task automatic wait_verdicts_drained();
		item_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic reg_sel, input logic [31:0] value);
		logic [31:0] width_mask;
		width_mask = (reg_sel == REG_SUBMODEL) ? 32'h0000_1FFF : 32'hFFFF_FFFF;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (reg_sel == REG_SUBMODEL)
			submodel_reg = value[12:0];
		else
			mask_reg = value;
		@(negedge clk);
		// read back
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & width_mask) !== (value & width_mask)) begin
			$error("register %0d readback: expected 0x%0h, got 0x%0h", reg_sel,
				value & width_mask, prdata);
			fail_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mask is still zero: every open misses, everything else is ignored.
	task automatic test_reset_defaults();
		cpvc_in_t it;
		it = random_item();
		it.req_type = REQ_PLANE;
		push_item(it);
		it = random_item();
		it.req_type = REQ_VERTEX;
		push_item(it);
		it = random_item();
		it.req_type = REQ_UNUSED;
		push_item(it);
		it = random_item();
		it.req_type = REQ_OPEN;
		it.polytope_index = fresh_index();
		it.polytope_contents = 32'hFFFF_FFFF;
		push_item(it);
	endtask

	// Top register values, hit with no planes, repeat vertex, repeat open.
	task automatic test_register_extremes();
		cpvc_in_t it;
		wait_verdicts_drained();
		write_reg(REG_CONTENT_MASK, 32'hFFFF_FFFF);
		write_reg(REG_SUBMODEL, 32'h0000_1FFF);
		it = random_item();
		it.req_type = REQ_OPEN;
		it.polytope_index = 10'd1023;
		push_item(it);
		it = random_item();
		it.req_type = REQ_VERTEX;
		it.vertex_number = 5'd31;
		push_item(it);
		it.vertex_number = 5'd0;
		push_item(it);
		it = random_item();
		it.req_type = REQ_OPEN;
		it.polytope_index = 10'd1023;
		push_item(it);
		it = random_item();
		it.req_type = REQ_PLANE;
		push_item(it);
	endtask

	// Field extremes, distance exactly zero, and contents miss under a narrow mask.
	task automatic test_plane_geometry();
		cpvc_in_t it;
		it = random_item();
		it.req_type = REQ_OPEN;
		it.polytope_index = 10'd0;
		it.polytope_contents = 32'h0000_0001;
		push_item(it);
		it = random_item();
		it.req_type = REQ_PLANE;
		it.normal_x = 16'sd16384;
		it.normal_y = 16'sd0;
		it.normal_z = 16'sd0;
		it.plane_offset = -32'sd256;
		push_item(it);
		it.normal_x = -16'sd16384;
		it.normal_y = -16'sd16384;
		it.normal_z = -16'sd16384;
		it.plane_offset = 32'h8000_0000;
		push_item(it);
		it = random_item();
		it.req_type = REQ_VERTEX;
		it.vertex_x = 24'sd256;
		it.vertex_y = '0;
		it.vertex_z = '0;
		push_item(it);
		it.vertex_x = 24'h7F_FFFF;
		push_item(it);
		it.vertex_x = 24'h80_0000;
		it.vertex_number = 5'd0;
		push_item(it);
		it.vertex_x = 24'h80_0000;
		it.vertex_number = 5'd7;
		push_item(it);

		wait_verdicts_drained();
		write_reg(REG_CONTENT_MASK, 32'h0000_0001);
		write_reg(REG_SUBMODEL, 32'h0000_0000);
		it = random_item();
		it.req_type = REQ_OPEN;
		it.polytope_index = fresh_index();
		it.polytope_contents = 32'hFFFF_FFFE;
		push_item(it);
		it.polytope_index = fresh_index();
		it.polytope_contents = 32'h0000_0001;
		push_item(it);
		it = random_item();
		it.req_type = REQ_PLANE;
		it.normal_x = '0;
		it.normal_y = '0;
		it.normal_z = '0;
		it.plane_offset = 32'h7FFF_FFFF;
		push_item(it);
		it = random_item();
		it.req_type = REQ_VERTEX;
		push_item(it);
	endtask

	// One polytope: open, planes, vertices; a small share is noise or broken.
	task automatic run_sequence();
		cpvc_in_t it;
		int choice;
		int planes;
		int verts;
		int span;
		choice = $urandom_range(0, 99);
		if (choice < 10) begin
			it = random_item();
			if (it.req_type == REQ_OPEN && $urandom_range(0, 1))
				it.polytope_index = last_opened;
			push_item(it);
			return;
		end
		it = random_item();
		it.req_type = REQ_OPEN;
		it.polytope_index = fresh_index();
		if (choice < 15)
			it.polytope_contents = $urandom() & ~mask_reg;
		else if (choice < 19)
			it.polytope_index = last_opened;
		else if (choice < 80)
			it.polytope_contents = $urandom() | mask_reg;
		push_item(it);

		planes = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
		case ($urandom_range(0, 3))
			0: span = 32'h100;
			1: span = 32'h1000;
			2: span = 32'h10000;
			default: span = 32'h7F_FFFF;
		endcase
		for (int p = 0; p < planes; p++) begin
			it = random_item();
			it.req_type = REQ_PLANE;
			if ($urandom_range(0, 9) < 8)
				it.plane_offset = -32'(int'($urandom_range(0, 32'h40_0000)));
			push_item(it);
		end
		verts = $urandom_range(1, 5);
		for (int v = 0; v < verts; v++) begin
			it = random_item();
			it.req_type = REQ_VERTEX;
			if ($urandom_range(0, 9) < 8) begin
				it.vertex_x = rand_coord(span);
				it.vertex_y = rand_coord(span);
				it.vertex_z = rand_coord(span);
			end
			push_item(it);
		end
	endtask

	task automatic test_random_traffic();
		int target;
		for (int phase = 0; phase < 8; phase++) begin
			// sender holds until the block is idle before each register change
			wait_verdicts_drained();
			case (phase)
				0: begin
					write_reg(REG_CONTENT_MASK, 32'hFFFF_FFFF);
					write_reg(REG_SUBMODEL, $urandom());
				end
				1: begin
					write_reg(REG_CONTENT_MASK, $urandom() | 32'h1);
					write_reg(REG_SUBMODEL, $urandom());
				end
				2: begin
					write_reg(REG_CONTENT_MASK, 32'h1 << $urandom_range(0, 31));
					write_reg(REG_SUBMODEL, 32'h1FFF);
				end
				3: begin
					write_reg(REG_CONTENT_MASK, 32'hFFFF_FFFF);
					write_reg(REG_SUBMODEL, 32'h0);
				end
				4: begin
					write_reg(REG_CONTENT_MASK, 32'h8000_0000);
					write_reg(REG_SUBMODEL, 32'h0AAA);
				end
				5: begin
					write_reg(REG_CONTENT_MASK, $urandom() | 32'h100);
					write_reg(REG_SUBMODEL, $urandom());
				end
				6: begin
					write_reg(REG_CONTENT_MASK, 32'hFFFF_FFFF);
					write_reg(REG_SUBMODEL, 32'h1FFF);
				end
				default: begin
					write_reg(REG_CONTENT_MASK, 32'h0000_FFFF);
					write_reg(REG_SUBMODEL, $urandom());
				end
			endcase
			quiet_run = (phase == 3);
			target = items_sent + 140;
			while (items_sent < target)
				run_sequence();
		end
		quiet_run = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_register_extremes();
		test_plane_geometry();
		test_random_traffic();
		wait_verdicts_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_verdicts.size() != 0) begin
			$error("%0d results never arrived", pending_verdicts.size());
			fail_count++;
		end
		$display("covered %0d items, %0d worked: %0d opened, %0d already marked, %0d missed",
			items_sent, items_worked, status_seen[ST_OPENED], status_seen[ST_MARKED],
			status_seen[ST_MISS]);
		$display("  %0d planes stored, %0d overflowed, %0d hits, %0d outside or ignored",
			status_seen[ST_STORED], status_seen[ST_OVERFLOW], status_seen[ST_HIT],
			status_seen[ST_IGNORED]);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/cpvc_pkg.sv
hw/rtl/cpvc_ram.sv
hw/rtl/cpvc_ctrl.sv
hw/rtl/cpvc_datapath.sv
hw/rtl/convex_polytope_vertex_containment.sv
hw/rtl/cpvc_checker.sv
tb/sv/tb.sv
